// ===== rtl/rsi_pkg.sv =====
// ray segment against sphere: shared types and constants
// payload structs for both channels and the internal pipeline record
`timescale 1ns / 1ps
package rsi_pkg;

  localparam int SQ1_W    = 37;  // root bits of the discriminant square root
  localparam int SQ2_W    = 31;  // root bits of the normal length square root
  localparam int DIV_QW   = 17;  // quotient bits of the normal divide
  localparam int NUM_W    = 45;  // dividend bits of the normal divide
  localparam int LEN_W    = 31;  // divisor bits of the normal divide
  localparam int NRM_TOP  = 19;  // msb position of the scaled normal
  localparam logic [16:0] NRM_POS_MAX = 17'd32767;
  localparam logic [16:0] NRM_NEG_MAX = 17'd32768;
  localparam logic [47:0] RND_HALF    = 48'd8192;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic        [30:0] seg_length;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic        [30:0] sphere_radius;
  } in_t;

  typedef struct packed {
    logic               is_hit;
    logic        [30:0] hit_distance;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
  } out_t;

  typedef struct packed {
    logic [2:0][31:0] s;
    logic [2:0][15:0] d;
    logic [2:0][31:0] c;
    logic [30:0]      len;
    logic [30:0]      rad;
    logic [2:0][32:0] oc;
    logic [2:0][48:0] pd;
    logic [2:0][65:0] osq;
    logic [61:0]      r2;
    logic [36:0]      b;
    logic [36:0]      bm;
    logic [37:0]      bhh;
    logic [36:0]      bhl;
    logic [35:0]      bll;
    logic [73:0]      pos;
    logic [66:0]      neg;
    logic [73:0]      disc;
    logic             miss;
    logic [36:0]      sq;
    logic [38:0]      t1;
    logic [38:0]      t2;
    logic             hit;
    logic [30:0]      t;
    logic [2:0][47:0] tp;
    logic [2:0][33:0] rr;
    logic [2:0][31:0] p;
    logic [2:0][32:0] n;
    logic [2:0][32:0] a;
    logic [2:0]       nsg;
    logic [32:0]      m;
    logic             nz;
    logic [5:0]       top;
    logic [2:0][19:0] an;
    logic [2:0][39:0] asq;
    logic [61:0]      x2;
    logic [30:0]      nlen;
    logic [2:0][44:0] num;
  } pipe_t;

endpackage

// ===== rtl/rsi_sqrt_pipe.sv =====
// pipelined floor square root, one root bit per register stage
// carries an opaque payload alongside; depends on nothing else
`timescale 1ns / 1ps
module rsi_sqrt_pipe #(
  parameter int RW = 16,
  parameter int PW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [2*RW-1:0] in_rad,
  input  logic [PW-1:0]   in_pay,
  output logic            out_valid,
  output logic [RW-1:0]   out_root,
  output logic [PW-1:0]   out_pay
);

  logic              v_r    [RW];
  logic [2*RW-1:0]   x_r    [RW];
  logic [RW:0]       rem_r  [RW];
  logic [RW-1:0]     root_r [RW];
  logic [PW-1:0]     pay_r  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic            v_in;
    logic [2*RW-1:0] x_in;
    logic [RW:0]     rem_in;
    logic [RW-1:0]   root_in;
    logic [PW-1:0]   pay_in;
    logic [RW+2:0]   sh;
    logic [RW+2:0]   trial;
    logic [RW:0]     rem_nxt;
    logic [RW-1:0]   root_nxt;

    if (k == 0) begin : g_head
      assign v_in    = in_valid;
      assign x_in    = in_rad;
      assign rem_in  = '0;
      assign root_in = '0;
      assign pay_in  = in_pay;
    end else begin : g_body
      assign v_in    = v_r[k-1];
      assign x_in    = x_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign pay_in  = pay_r[k-1];
    end

    always_comb begin
      sh    = {rem_in, x_in[2*RW-1 -: 2]};
      trial = {1'b0, root_in, 2'b01};
      if (sh >= trial) begin
        rem_nxt  = (RW+1)'(sh - trial);
        root_nxt = {root_in[RW-2:0], 1'b1};
      end else begin
        rem_nxt  = sh[RW:0];
        root_nxt = {root_in[RW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      x_r[k]    <= x_in << 2;
      rem_r[k]  <= rem_nxt;
      root_r[k] <= root_nxt;
      pay_r[k]  <= pay_in;
    end
  end

  assign out_valid = v_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_pay   = pay_r[RW-1];

endmodule

// ===== rtl/rsi_div_pipe.sv =====
// pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor; carries an opaque payload; depends on nothing else
`timescale 1ns / 1ps
module rsi_div_pipe #(
  parameter int QW    = 17,
  parameter int NW    = 45,
  parameter int DW    = 31,
  parameter int LANES = 3,
  parameter int PW    = 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [LANES-1:0][NW-1:0]  in_num,
  input  logic [DW-1:0]             in_den,
  input  logic [PW-1:0]             in_pay,
  output logic                      out_valid,
  output logic [LANES-1:0][QW-1:0]  out_quo,
  output logic [PW-1:0]             out_pay
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic                     v_r   [QW];
  logic [LANES-1:0][NW-1:0] rem_r [QW];
  logic [LANES-1:0][QW-1:0] quo_r [QW];
  logic [DW-1:0]            den_r [QW];
  logic [PW-1:0]            pay_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int SH = QW - 1 - k;
    logic                     v_in;
    logic [LANES-1:0][NW-1:0] rem_in;
    logic [LANES-1:0][QW-1:0] quo_in;
    logic [DW-1:0]            den_in;
    logic [PW-1:0]            pay_in;
    logic [CW-1:0]            trial;
    logic [CW-1:0]            remx  [LANES];
    logic [LANES-1:0][NW-1:0] rem_nxt;
    logic [LANES-1:0][QW-1:0] quo_nxt;

    if (k == 0) begin : g_head
      assign v_in   = in_valid;
      assign rem_in = in_num;
      assign quo_in = '0;
      assign den_in = in_den;
      assign pay_in = in_pay;
    end else begin : g_body
      assign v_in   = v_r[k-1];
      assign rem_in = rem_r[k-1];
      assign quo_in = quo_r[k-1];
      assign den_in = den_r[k-1];
      assign pay_in = pay_r[k-1];
    end

    always_comb begin
      trial = CW'(den_in) << SH;
      for (int l = 0; l < LANES; l++) begin
        remx[l] = CW'(rem_in[l]);
        if (remx[l] >= trial) begin
          rem_nxt[l] = NW'(remx[l] - trial);
          quo_nxt[l] = {quo_in[l][QW-2:0], 1'b1};
        end else begin
          rem_nxt[l] = rem_in[l];
          quo_nxt[l] = {quo_in[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= rem_nxt;
      quo_r[k] <= quo_nxt;
      den_r[k] <= den_in;
      pay_r[k] <= pay_in;
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_quo   = quo_r[QW-1];
  assign out_pay   = pay_r[QW-1];

endmodule

// ===== rtl/ray_sphere_intersect_unit.sv =====
// ray segment against sphere intersection, fully pipelined top level
// uses rsi_pkg, rsi_sqrt_pipe and rsi_div_pipe
`timescale 1ns / 1ps
// usage:
//   a ray item is a transfer on the input side when start is high and busy
//   is low. busy is always low: the pipeline takes one item every cycle.
//   every item gives exactly one result, shown on out_data for one cycle
//   with out_valid high. the receiver must take it in that cycle.
//   throughput is one item per cycle. the latency is set by the two
//   pipelined square roots (37 and 31 stages) and the 17-stage normal
//   divider, plus 21 setup stages.
//   on a miss every result field is zero; when the hit point sits on the
//   center the normal is zero.
//   reset (rst_n low, synchronous) clears every valid bit, so items in
//   flight are dropped and no result comes out until new items enter.
module ray_sphere_intersect_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  rsi_pkg::in_t   in_data,
  output logic           out_valid,
  output rsi_pkg::out_t  out_data
);

  localparam int FN  = 7;
  localparam int MN  = 12;
  localparam int LAT = FN + rsi_pkg::SQ1_W + MN + rsi_pkg::SQ2_W + 1
                       + rsi_pkg::DIV_QW + 1;
  localparam int PW  = $bits(rsi_pkg::pipe_t);

  logic acc;

  // front: oc, dot product, b, squares, discriminant
  rsi_pkg::pipe_t f_r   [FN];
  rsi_pkg::pipe_t f_nxt [FN];
  logic [FN-1:0]  f_v_r;

  logic signed [50:0] dot;
  logic [74:0]        diff;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  always_comb begin
    f_nxt[0]      = '0;
    f_nxt[0].s[0] = in_data.start_x;
    f_nxt[0].s[1] = in_data.start_y;
    f_nxt[0].s[2] = in_data.start_z;
    f_nxt[0].d[0] = in_data.dir_x;
    f_nxt[0].d[1] = in_data.dir_y;
    f_nxt[0].d[2] = in_data.dir_z;
    f_nxt[0].c[0] = in_data.center_x;
    f_nxt[0].c[1] = in_data.center_y;
    f_nxt[0].c[2] = in_data.center_z;
    f_nxt[0].len  = in_data.seg_length;
    f_nxt[0].rad  = in_data.sphere_radius;
    for (int i = 0; i < 3; i++) begin
      f_nxt[0].oc[i] = $signed({f_nxt[0].s[i][31], f_nxt[0].s[i]})
                       - $signed({f_nxt[0].c[i][31], f_nxt[0].c[i]});
    end

    f_nxt[1] = f_r[0];
    for (int i = 0; i < 3; i++) begin
      f_nxt[1].pd[i]  = $signed(f_r[0].d[i]) * $signed(f_r[0].oc[i]);
      f_nxt[1].osq[i] = $signed(f_r[0].oc[i]) * $signed(f_r[0].oc[i]);
    end
    f_nxt[1].r2 = f_r[0].rad * f_r[0].rad;

    f_nxt[2] = f_r[1];
    dot = $signed(f_r[1].pd[0]) + $signed(f_r[1].pd[1]) + $signed(f_r[1].pd[2])
          + $signed({3'b0, rsi_pkg::RND_HALF});
    f_nxt[2].b   = dot[50:14];
    f_nxt[2].neg = {1'b0, f_r[1].osq[0]} + {1'b0, f_r[1].osq[1]}
                   + {1'b0, f_r[1].osq[2]};

    f_nxt[3]    = f_r[2];
    f_nxt[3].bm = f_r[2].b[36] ? (~f_r[2].b + 37'd1) : f_r[2].b;

    f_nxt[4]     = f_r[3];
    f_nxt[4].bhh = f_r[3].bm[36:18] * f_r[3].bm[36:18];
    f_nxt[4].bhl = f_r[3].bm[36:18] * f_r[3].bm[17:0];
    f_nxt[4].bll = f_r[3].bm[17:0] * f_r[3].bm[17:0];

    f_nxt[5]     = f_r[4];
    f_nxt[5].pos = {f_r[4].bhh, 36'b0} + {18'b0, f_r[4].bhl, 19'b0}
                   + {38'b0, f_r[4].bll} + {12'b0, f_r[4].r2};

    f_nxt[6]      = f_r[5];
    diff          = {1'b0, f_r[5].pos} - {8'b0, f_r[5].neg};
    f_nxt[6].miss = diff[74];
    f_nxt[6].disc = diff[73:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= '0;
    end else begin
      f_v_r <= {f_v_r[FN-2:0], acc};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < FN; k++) begin
      f_r[k] <= f_nxt[k];
    end
  end

  // discriminant square root
  logic                     s1_v;
  logic [rsi_pkg::SQ1_W-1:0] s1_root;
  logic [PW-1:0]            s1_pay_w;
  rsi_pkg::pipe_t           s1_pay;

  rsi_sqrt_pipe #(
    .RW (rsi_pkg::SQ1_W),
    .PW (PW)
  ) u_sqrt_disc (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_v_r[FN-1]),
    .in_rad    (f_r[FN-1].disc),
    .in_pay    (f_r[FN-1]),
    .out_valid (s1_v),
    .out_root  (s1_root),
    .out_pay   (s1_pay_w)
  );

  assign s1_pay = rsi_pkg::pipe_t'(s1_pay_w);

  // middle: roots, hit point, normal scaling
  rsi_pkg::pipe_t m_r   [MN];
  rsi_pkg::pipe_t m_nxt [MN];
  logic [MN-1:0]  m_v_r;

  logic signed [38:0] t1c;
  logic signed [38:0] t2c;
  logic               in1;
  logic               in2;
  logic signed [47:0] rsum [3];
  logic signed [34:0] psum [3];
  logic signed [32:0] ndif [3];
  logic [32:0]        mx;
  logic [32:0]        ash  [3];
  logic [41:0]        l2s;

  always_comb begin
    m_nxt[0]    = s1_pay;
    m_nxt[0].sq = s1_root;
    t1c = -$signed(s1_pay.b) - $signed({2'b0, s1_root});
    t2c = -$signed(s1_pay.b) + $signed({2'b0, s1_root});
    m_nxt[0].t1 = t1c;
    m_nxt[0].t2 = t2c;

    m_nxt[1] = m_r[0];
    in1 = !m_r[0].t1[38] && (m_r[0].t1 <= {8'b0, m_r[0].len});
    in2 = !m_r[0].t2[38] && (m_r[0].t2 <= {8'b0, m_r[0].len});
    m_nxt[1].hit = !m_r[0].miss && (in1 || in2);
    if (!m_nxt[1].hit) begin
      m_nxt[1].t = '0;
    end else if (in1) begin
      m_nxt[1].t = m_r[0].t1[30:0];
    end else begin
      m_nxt[1].t = m_r[0].t2[30:0];
    end

    m_nxt[2] = m_r[1];
    for (int i = 0; i < 3; i++) begin
      m_nxt[2].tp[i] = $signed({1'b0, m_r[1].t}) * $signed(m_r[1].d[i]);
    end

    m_nxt[3] = m_r[2];
    for (int i = 0; i < 3; i++) begin
      rsum[i]        = $signed(m_r[2].tp[i]) + $signed(rsi_pkg::RND_HALF);
      m_nxt[3].rr[i] = rsum[i][47:14];
    end

    m_nxt[4] = m_r[3];
    for (int i = 0; i < 3; i++) begin
      psum[i] = $signed(m_r[3].s[i]) + $signed(m_r[3].rr[i]);
      if (!psum[i][34] && (psum[i][33:31] != 3'b000)) begin
        m_nxt[4].p[i] = 32'h7fff_ffff;
      end else if (psum[i][34] && (psum[i][33:31] != 3'b111)) begin
        m_nxt[4].p[i] = 32'h8000_0000;
      end else begin
        m_nxt[4].p[i] = psum[i][31:0];
      end
    end

    m_nxt[5] = m_r[4];
    for (int i = 0; i < 3; i++) begin
      ndif[i]       = $signed(m_r[4].p[i]) - $signed(m_r[4].c[i]);
      m_nxt[5].n[i] = ndif[i];
    end

    m_nxt[6] = m_r[5];
    for (int i = 0; i < 3; i++) begin
      m_nxt[6].nsg[i] = m_r[5].n[i][32];
      m_nxt[6].a[i]   = m_r[5].n[i][32] ? (~m_r[5].n[i] + 33'd1) : m_r[5].n[i];
    end

    m_nxt[7] = m_r[6];
    mx = m_r[6].a[0];
    if (m_r[6].a[1] > mx) begin
      mx = m_r[6].a[1];
    end
    if (m_r[6].a[2] > mx) begin
      mx = m_r[6].a[2];
    end
    m_nxt[7].m  = mx;
    m_nxt[7].nz = (mx != '0);

    m_nxt[8]     = m_r[7];
    m_nxt[8].top = '0;
    for (int j = 0; j < 33; j++) begin
      if (m_r[7].m[j]) begin
        m_nxt[8].top = 6'(j);
      end
    end

    m_nxt[9] = m_r[8];
    for (int i = 0; i < 3; i++) begin
      if (m_r[8].top > 6'(rsi_pkg::NRM_TOP)) begin
        ash[i] = m_r[8].a[i] >> (m_r[8].top - 6'(rsi_pkg::NRM_TOP));
      end else begin
        ash[i] = m_r[8].a[i] << (6'(rsi_pkg::NRM_TOP) - m_r[8].top);
      end
      m_nxt[9].an[i] = ash[i][19:0];
    end

    m_nxt[10] = m_r[9];
    for (int i = 0; i < 3; i++) begin
      m_nxt[10].asq[i] = m_r[9].an[i] * m_r[9].an[i];
    end

    m_nxt[11]    = m_r[10];
    l2s          = {2'b0, m_r[10].asq[0]} + {2'b0, m_r[10].asq[1]}
                   + {2'b0, m_r[10].asq[2]};
    m_nxt[11].x2 = {l2s, 20'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= '0;
    end else begin
      m_v_r <= {m_v_r[MN-2:0], s1_v};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MN; k++) begin
      m_r[k] <= m_nxt[k];
    end
  end

  // normal length square root
  logic                     s2_v;
  logic [rsi_pkg::SQ2_W-1:0] s2_root;
  logic [PW-1:0]            s2_pay_w;
  rsi_pkg::pipe_t           s2_pay;

  rsi_sqrt_pipe #(
    .RW (rsi_pkg::SQ2_W),
    .PW (PW)
  ) u_sqrt_len (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (m_v_r[MN-1]),
    .in_rad    (m_r[MN-1].x2),
    .in_pay    (m_r[MN-1]),
    .out_valid (s2_v),
    .out_root  (s2_root),
    .out_pay   (s2_pay_w)
  );

  assign s2_pay = rsi_pkg::pipe_t'(s2_pay_w);

  // dividends with half-divisor rounding
  rsi_pkg::pipe_t q_r;
  rsi_pkg::pipe_t q_nxt;
  logic           q_v_r;

  always_comb begin
    q_nxt      = s2_pay;
    q_nxt.nlen = s2_root;
    for (int i = 0; i < 3; i++) begin
      q_nxt.num[i] = {1'b0, s2_pay.an[i], 24'b0} + {15'b0, s2_root[30:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_v_r <= 1'b0;
    end else begin
      q_v_r <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  logic                             dv_v;
  logic [2:0][rsi_pkg::DIV_QW-1:0]  dv_quo;
  logic [PW-1:0]                    dv_pay_w;
  rsi_pkg::pipe_t                   dv_pay;

  rsi_div_pipe #(
    .QW    (rsi_pkg::DIV_QW),
    .NW    (rsi_pkg::NUM_W),
    .DW    (rsi_pkg::LEN_W),
    .LANES (3),
    .PW    (PW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_v_r),
    .in_num    (q_r.num),
    .in_den    (q_r.nlen),
    .in_pay    (q_r),
    .out_valid (dv_v),
    .out_quo   (dv_quo),
    .out_pay   (dv_pay_w)
  );

  assign dv_pay = rsi_pkg::pipe_t'(dv_pay_w);

  // result register
  rsi_pkg::out_t out_r;
  rsi_pkg::out_t out_nxt;
  logic          out_valid_r;
  logic [15:0]   nrm [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!dv_pay.nz) begin
        nrm[i] = '0;
      end else if (dv_pay.nsg[i]) begin
        nrm[i] = (dv_quo[i] > rsi_pkg::NRM_NEG_MAX) ? 16'h8000 : 16'(-dv_quo[i]);
      end else begin
        nrm[i] = (dv_quo[i] > rsi_pkg::NRM_POS_MAX) ? 16'h7fff : dv_quo[i][15:0];
      end
    end
    out_nxt = '0;
    if (dv_pay.hit) begin
      out_nxt.is_hit       = 1'b1;
      out_nxt.hit_distance = dv_pay.t;
      out_nxt.point_x      = dv_pay.p[0];
      out_nxt.point_y      = dv_pay.p[1];
      out_nxt.point_z      = dv_pay.p[2];
      out_nxt.normal_x     = nrm[0];
      out_nxt.normal_y     = nrm[1];
      out_nxt.normal_z     = nrm[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##LAT out_valid)
    else $error("input transfer without result at fixed latency");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.is_hit) |-> (out_data.hit_distance == '0
      && out_data.point_x == '0 && out_data.point_y == '0
      && out_data.point_z == '0 && out_data.normal_x == '0
      && out_data.normal_y == '0 && out_data.normal_z == '0))
    else $error("miss result carries nonzero fields");

  a_t_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (m_v_r[1] && m_r[1].hit) |-> (m_r[1].t <= m_r[1].len))
    else $error("chosen root beyond segment length");

  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result strobe right after reset");
`endif

endmodule
